// ===== rtl/core/hwrw_pkg.sv =====
package hwrw_pkg;

  localparam int unsigned NUM_LIGHTS_DEF = 16;

  localparam int unsigned PHASE_W   = 19;
  localparam int unsigned HUE_W     = 11;
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned QDEPTH    = 2;

  localparam logic [PHASE_W:0] PHASE_MOD = 20'd393216;
  localparam logic [HUE_W:0]   HUE_MOD   = 12'd1536;
  localparam logic [HUE_W-1:0] HUE_MAX   = 11'd1535;
  localparam logic [COLOR_W-1:0] FULL    = 8'hff;

  // register indexes on the config port
  localparam logic [1:0] REG_DIRECTION  = 2'd0;
  localparam logic [1:0] REG_PHASE_STEP = 2'd1;
  localparam logic [1:0] REG_HUE_OFFSET = 2'd2;

  typedef struct packed {
    logic              direction;
    logic [STEP_W-1:0] phase_step;
    logic [HUE_W-1:0]  hue_offset;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // six-sector colour wheel
  function automatic rgb_t wheel(input logic [HUE_W-1:0] hue);
    rgb_t               c;
    logic [COLOR_W-1:0] ramp;
    ramp = hue[COLOR_W-1:0];
    case (hue[HUE_W-1:COLOR_W])
      3'd0: c = '{red: FULL, green: '0, blue: ramp};
      3'd1: c = '{red: FULL - ramp, green: '0, blue: FULL};
      3'd2: c = '{red: '0, green: ramp, blue: FULL};
      3'd3: c = '{red: '0, green: FULL, blue: FULL - ramp};
      3'd4: c = '{red: ramp, green: FULL, blue: '0};
      default: c = '{red: FULL, green: FULL - ramp, blue: '0};
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/hwrw_front.sv =====
module hwrw_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hwrw_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_advance,
  input  logic                        q_full,
  output logic                        push,
  output logic [hwrw_pkg::HUE_W-1:0]  push_hue
);
  import hwrw_pkg::*;

  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  logic [PHASE_W:0]   up_sum;
  logic [PHASE_W:0]   down_sum;
  logic [PHASE_W-1:0] stepped;

  assign up_sum   = {1'b0, phase_r} + {{(PHASE_W+1-STEP_W){1'b0}}, cfg.phase_step};
  assign down_sum = {1'b0, phase_r} - {{(PHASE_W+1-STEP_W){1'b0}}, cfg.phase_step};

  always_comb begin
    if (!cfg.direction) begin
      if (up_sum >= PHASE_MOD) begin
        stepped = PHASE_W'(up_sum - PHASE_MOD);
      end else begin
        stepped = up_sum[PHASE_W-1:0];
      end
    end else begin
      // borrow out of the subtract means the phase wrapped below zero
      if (down_sum[PHASE_W]) begin
        stepped = PHASE_W'(down_sum + PHASE_MOD);
      end else begin
        stepped = down_sum[PHASE_W-1:0];
      end
    end
  end

  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready;
  assign phase_nxt = in_advance ? stepped : phase_r;
  assign push_hue  = phase_nxt[PHASE_W-1:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (push) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== rtl/core/hwrw_queue.sv =====
module hwrw_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [hwrw_pkg::HUE_W-1:0]  push_hue,
  input  logic                        pop,
  output logic                        q_valid,
  output logic                        q_full,
  output logic [hwrw_pkg::HUE_W-1:0]  q_hue
);
  import hwrw_pkg::*;

  localparam int unsigned PTR_W = $clog2(QDEPTH);

  logic [HUE_W-1:0] mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic [PTR_W:0]   count_nxt;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == (PTR_W+1)'(QDEPTH));
  assign q_hue   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_hue;
    end
  end

endmodule

// ===== rtl/core/hwrw_back.sv =====
module hwrw_back #(
  parameter int unsigned NUM_LIGHTS = hwrw_pkg::NUM_LIGHTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hwrw_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  input  logic [hwrw_pkg::HUE_W-1:0]    q_hue,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hwrw_pkg::IDX_W-1:0]    out_light_index,
  output logic [hwrw_pkg::COLOR_W-1:0]  out_red,
  output logic [hwrw_pkg::COLOR_W-1:0]  out_green,
  output logic [hwrw_pkg::COLOR_W-1:0]  out_blue,
  output logic                          out_last
);
  import hwrw_pkg::*;

  logic               busy_r;
  logic [IDX_W-1:0]   light_r;
  logic [HUE_W-1:0]   hue_r;
  logic [HUE_W:0]     hue_sum;
  logic [HUE_W-1:0]   hue_nxt;
  logic               adv;
  logic               is_last;
  rgb_t               color;

  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;
  rgb_t               out_rgb_r;
  logic               out_last_r;

  assign adv     = busy_r && (!out_valid_r || out_ready);
  assign is_last = (light_r == IDX_W'(NUM_LIGHTS - 1));
  assign pop     = q_valid && (!busy_r || (adv && is_last));
  assign color   = wheel(hue_r);

  assign hue_sum = {1'b0, hue_r} + {1'b0, cfg.hue_offset};
  assign hue_nxt = (hue_sum >= HUE_MOD) ? HUE_W'(hue_sum - HUE_MOD) : hue_sum[HUE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      light_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        light_r     <= light_r + 1'b1;
        if (is_last) begin
          busy_r <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        busy_r  <= 1'b1;
        light_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hue_r <= q_hue;
    end else if (adv) begin
      hue_r <= hue_nxt;
    end
    if (adv) begin
      out_idx_r  <= light_r;
      out_rgb_r  <= color;
      out_last_r <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_light_index = out_idx_r;
  assign out_red         = out_rgb_r.red;
  assign out_green       = out_rgb_r.green;
  assign out_blue        = out_rgb_r.blue;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/core/hue_wheel_rainbow_wash_top.sv =====
// rainbow / colour-wash generator on a 1536-step colour wheel. every input transfer
// (advance = 1 steps the 19-bit hue phase by phase_step, up or down per direction, wrapping
// at 393216; advance = 0 leaves it) produces NUM_LIGHTS result transfers, one per light in
// light order with last set on the final one. light 0 takes the integer hue (phase >> 8),
// each later light adds hue_offset modulo 1536, so hue_offset = 0 gives a uniform wash.
// the back-end sequencer emits one light per cycle while out_ready stays high and loads the
// next queued hue with the last light of a run. input transfers are taken one per cycle
// while the two-entry hue queue has room; when the back end is free, an input transfer goes
// through the queue, the hue register and the output register to its first result.
// registers (byte address): 0x0 direction, 0x4 phase_step, 0x8 hue_offset (a write whose
// low 11 bits exceed 1535 clamps to 1535). write config only while the block is idle.
module hue_wheel_rainbow_wash_top #(
  parameter int unsigned NUM_LIGHTS = hwrw_pkg::NUM_LIGHTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // tick input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_advance,
  // colour output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hwrw_pkg::IDX_W-1:0]    out_light_index,
  output logic [hwrw_pkg::COLOR_W-1:0]  out_red,
  output logic [hwrw_pkg::COLOR_W-1:0]  out_green,
  output logic [hwrw_pkg::COLOR_W-1:0]  out_blue,
  output logic                          out_last
);
  import hwrw_pkg::*;

  cfg_t             cfg_r;
  logic             wr_en;
  logic [1:0]       reg_idx;
  logic [HUE_W-1:0] offset_wr;

  logic             push;
  logic [HUE_W-1:0] push_hue;
  logic             pop;
  logic             q_valid;
  logic             q_full;
  logic [HUE_W-1:0] q_hue;

  // register file, written in the access phase
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[3:2];
  assign offset_wr = (pwdata[HUE_W-1:0] > HUE_MAX) ? HUE_MAX : pwdata[HUE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DIRECTION:  cfg_r.direction  <= pwdata[0];
        REG_PHASE_STEP: cfg_r.phase_step <= pwdata[STEP_W-1:0];
        REG_HUE_OFFSET: cfg_r.hue_offset <= offset_wr;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIRECTION:  prdata = {31'd0, cfg_r.direction};
      REG_PHASE_STEP: prdata = {{(32-STEP_W){1'b0}}, cfg_r.phase_step};
      REG_HUE_OFFSET: prdata = {{(32-HUE_W){1'b0}}, cfg_r.hue_offset};
      default:        prdata = '0;
    endcase
  end

  // front end: phase update and hue capture per tick
  hwrw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_advance (in_advance),
    .q_full     (q_full),
    .push       (push),
    .push_hue   (push_hue)
  );

  // decouples tick intake from the per-light run
  hwrw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_hue (push_hue),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_hue    (q_hue)
  );

  // back end: walks the lights, one colour triple per cycle to the output register unless stalled
  hwrw_back #(
    .NUM_LIGHTS (NUM_LIGHTS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_hue           (q_hue),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_light_index (out_light_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last        (out_last)
  );

endmodule
